// ===== src/i2cm_pkg.sv =====
// Shared types and command codes for the I2C master byte engine.
`default_nettype none

package i2cm_pkg;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_ACK   = 3'd5;
    localparam logic [2:0] CMD_NACK  = 3'd6;
    localparam logic [2:0] CMD_WAIT  = 3'd7;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd20;

    localparam logic [0:0] REG_HALF_PERIOD = 1'b0;
    localparam logic [0:0] REG_ACK_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } res_item_t;

    typedef struct packed {
        logic       has_cmd;
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       sda_in;
    } tick_entry_t;

    typedef struct packed {
        logic [15:0] half_period;
        logic [7:0]  ack_timeout;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/i2cm_fifo.sv =====
// Small flop-based queue used between the stages.
`default_nettype none

module i2cm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== src/i2cm_front.sv =====
// Front stage: accept and classify ticks, queue them for the engine.
`default_nettype none

module i2cm_front
    import i2cm_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire in_item_t    item,
    output logic             full,
    input  wire logic        q_pop,
    output tick_entry_t      q_entry,
    output logic             q_empty
);

    tick_entry_t entry;

    always_comb
    begin
        entry.has_cmd = (item.command != CMD_NONE);
        entry.command = item.command;
        entry.tx_byte = item.tx_byte;
        entry.sda_in  = item.sda_in;
    end

    i2cm_fifo #(
        .WIDTH ($bits(tick_entry_t)),
        .DEPTH (DEPTH)
    ) u_tick_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (entry),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_entry),
        .empty (q_empty)
    );

endmodule

`default_nettype wire

// ===== src/i2cm_engine.sv =====
// Back stage: bus phase sequencer, one queued tick per step.
`default_nettype none

module i2cm_engine
    import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        q_empty,
    input  wire tick_entry_t q_entry,
    output logic             q_pop,
    input  wire logic        res_full,
    output logic             res_push,
    output res_item_t        res_item
);

    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_ST_A = 5'd1;
    localparam logic [4:0] PH_ST_B = 5'd2;
    localparam logic [4:0] PH_SP_0 = 5'd3;
    localparam logic [4:0] PH_SP_A = 5'd4;
    localparam logic [4:0] PH_SP_B = 5'd5;
    localparam logic [4:0] PH_AK_A = 5'd6;
    localparam logic [4:0] PH_AK_B = 5'd7;
    localparam logic [4:0] PH_NK_A = 5'd8;
    localparam logic [4:0] PH_NK_B = 5'd9;
    localparam logic [4:0] PH_NK_C = 5'd10;
    localparam logic [4:0] PH_WA_A = 5'd11;
    localparam logic [4:0] PH_WA_P = 5'd12;
    localparam logic [4:0] PH_WA_C = 5'd13;
    localparam logic [4:0] PH_WR_A = 5'd14;
    localparam logic [4:0] PH_WR_B = 5'd15;
    localparam logic [4:0] PH_WR_C = 5'd16;
    localparam logic [4:0] PH_RD_A = 5'd17;
    localparam logic [4:0] PH_RD_B = 5'd18;

    logic [4:0]  phase_reg, phase_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] hold_reg, hold_next;
    logic [7:0]  wait_reg, wait_next;
    logic [1:0]  line_reg, line_next;
    logic [7:0]  rx_reg, rx_next;
    logic        ack_reg, ack_next;
    logic        done;
    logic        step;
    logic [15:0] half_eff;

    assign step     = !q_empty && !res_full;
    assign q_pop    = step;
    assign res_push = step;
    assign half_eff = (cfg.half_period == '0) ? 16'd1 : cfg.half_period;

    always_comb
    begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        hold_next  = hold_reg;
        wait_next  = wait_reg;
        line_next  = line_reg;
        rx_next    = rx_reg;
        ack_next   = ack_reg;
        done       = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            if (q_entry.has_cmd)
            begin
                hold_next = half_eff;
                case (q_entry.command)
                    CMD_START:
                    begin
                        phase_next = PH_ST_A;
                        line_next  = 2'b11;
                    end
                    CMD_STOP:
                    begin
                        phase_next = PH_SP_0;
                        line_next  = 2'b00;
                        hold_next  = 16'd1;
                    end
                    CMD_WRITE:
                    begin
                        shift_next = q_entry.tx_byte;
                        bit_next   = '0;
                        phase_next = PH_WR_A;
                        line_next  = {1'b0, q_entry.tx_byte[7]};
                    end
                    CMD_READ:
                    begin
                        shift_next = '0;
                        bit_next   = '0;
                        phase_next = PH_RD_A;
                        line_next  = 2'b01;
                    end
                    CMD_ACK:
                    begin
                        phase_next = PH_AK_A;
                        line_next  = 2'b00;
                    end
                    CMD_NACK:
                    begin
                        phase_next = PH_NK_A;
                        line_next  = {1'b0, line_reg[0]};
                    end
                    CMD_WAIT:
                    begin
                        ack_next   = 1'b0;
                        wait_next  = '0;
                        phase_next = PH_WA_A;
                        line_next  = 2'b11;
                    end
                    default:
                    begin
                        hold_next = hold_reg;
                    end
                endcase
            end
        end
        else if (phase_reg == PH_WA_P)
        begin
            if (q_entry.sda_in)
            begin
                if (wait_reg >= cfg.ack_timeout)
                begin
                    ack_next   = 1'b1;
                    phase_next = PH_SP_0;
                    line_next  = 2'b00;
                    hold_next  = 16'd1;
                end
                else
                begin
                    wait_next = wait_reg + 8'd1;
                end
            end
            else
            begin
                phase_next = PH_WA_C;
                line_next  = 2'b01;
                hold_next  = half_eff;
            end
        end
        else if (hold_reg > 16'd1)
        begin
            hold_next = hold_reg - 16'd1;
        end
        else
        begin
            hold_next = half_eff;
            case (phase_reg)
                PH_ST_A:
                begin
                    phase_next = PH_ST_B;
                    line_next  = 2'b10;
                end
                PH_ST_B:
                begin
                    line_next  = 2'b00;
                    phase_next = PH_IDLE;
                    hold_next  = hold_reg;
                    done       = 1'b1;
                end
                PH_SP_0:
                begin
                    phase_next = PH_SP_A;
                    line_next  = 2'b10;
                end
                PH_SP_A:
                begin
                    phase_next = PH_SP_B;
                    line_next  = 2'b11;
                end
                PH_AK_A:
                begin
                    phase_next = PH_AK_B;
                    line_next  = 2'b10;
                end
                PH_AK_B:
                begin
                    line_next  = 2'b00;
                    phase_next = PH_IDLE;
                    hold_next  = hold_reg;
                    done       = 1'b1;
                end
                PH_NK_A:
                begin
                    phase_next = PH_NK_B;
                    line_next  = 2'b01;
                end
                PH_NK_B:
                begin
                    phase_next = PH_NK_C;
                    line_next  = 2'b11;
                end
                PH_NK_C:
                begin
                    line_next  = 2'b01;
                    phase_next = PH_IDLE;
                    hold_next  = hold_reg;
                    done       = 1'b1;
                end
                PH_WA_A:
                begin
                    phase_next = PH_WA_P;
                    wait_next  = '0;
                    hold_next  = hold_reg;
                end
                PH_SP_B, PH_WA_C:
                begin
                    phase_next = PH_IDLE;
                    hold_next  = hold_reg;
                    done       = 1'b1;
                end
                PH_WR_A:
                begin
                    phase_next = PH_WR_B;
                    line_next  = {1'b1, shift_reg[7]};
                end
                PH_WR_B:
                begin
                    phase_next = PH_WR_C;
                    line_next  = {1'b0, shift_reg[7]};
                end
                PH_WR_C:
                begin
                    if (bit_reg == 3'd7)
                    begin
                        phase_next = PH_IDLE;
                        hold_next  = hold_reg;
                        done       = 1'b1;
                    end
                    else
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_WR_A;
                        line_next  = {1'b0, shift_reg[6]};
                    end
                end
                PH_RD_A:
                begin
                    phase_next = PH_RD_B;
                    line_next  = 2'b11;
                end
                PH_RD_B:
                begin
                    shift_next = {shift_reg[6:0], q_entry.sda_in};
                    if (bit_reg == 3'd7)
                    begin
                        rx_next    = {shift_reg[6:0], q_entry.sda_in};
                        phase_next = PH_IDLE;
                        hold_next  = hold_reg;
                        done       = 1'b1;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_RD_A;
                        line_next  = 2'b01;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    hold_next  = hold_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        res_item.scl_level   = line_next[1];
        res_item.sda_level   = line_next[0];
        res_item.busy_res    = (phase_next != PH_IDLE);
        res_item.done_res    = done;
        res_item.rx_byte     = rx_next;
        res_item.ack_missing = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bit_reg   <= '0;
            shift_reg <= '0;
            hold_reg  <= '0;
            wait_reg  <= '0;
            line_reg  <= 2'b11;
            rx_reg    <= '0;
            ack_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            hold_reg  <= hold_next;
            wait_reg  <= wait_next;
            line_reg  <= line_next;
            rx_reg    <= rx_next;
            ack_reg   <= ack_next;
        end
    end

    a_poll_scl_high: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WA_P) |-> line_reg[1])
        else $error("SCL not released while polling for ack");

    a_hold_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg != PH_IDLE && phase_reg != PH_WA_P && hold_reg > 16'd1)
        |=> (phase_reg == $past(phase_reg)))
        else $error("phase left before its hold count ran out");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && done) |=> (phase_reg == PH_IDLE))
        else $error("engine not idle after a finished command");

    a_timeout_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !ack_reg && ack_next) |=> (phase_reg == PH_SP_0))
        else $error("ack timeout did not enter stop");

endmodule

`default_nettype wire

// ===== src/i2c_master_byte_engine_top.sv =====
// Top level of the I2C master byte engine: config registers, front, engine, result queue.
//
//  port group  | handshake            | carries
//  ------------+----------------------+------------------------------------
//  item in     | push / full          | item: command, tx_byte, sda_in
//  result out  | pop / empty          | result: lines, busy, done, rx, ack
//  config      | psel/penable/pready  | half_period @0x0, ack_timeout @0x4
//
//  One tick item in, one result item out; sustained rate one item per cycle while the
//  result queue has room. The tick queue holds each accepted item, then the sequencer
//  steps and writes the result queue; a full result queue stalls that step.
//  The sequencer steps only when a tick is queued and the result queue has room.
//  Reset releases both lines and leaves the sequencer idle.
`default_nettype none

module i2c_master_byte_engine_top
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire in_item_t    item,
    output logic             full,
    input  wire logic        pop,
    output res_item_t        result,
    output logic             empty,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t        cfg_reg, cfg_next;
    tick_entry_t q_entry;
    logic        q_empty, q_pop;
    res_item_t   res_item;
    logic        res_push, res_full;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_HALF_PERIOD: cfg_next.half_period = pwdata[15:0];
                REG_ACK_TIMEOUT: cfg_next.ack_timeout = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_HALF_PERIOD: prdata = {16'd0, cfg_reg.half_period};
            REG_ACK_TIMEOUT: prdata = {24'd0, cfg_reg.ack_timeout};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period <= HALF_PERIOD_RESET;
            cfg_reg.ack_timeout <= ACK_TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    i2cm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .q_pop   (q_pop),
        .q_entry (q_entry),
        .q_empty (q_empty)
    );

    i2cm_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_item (res_item)
    );

    i2cm_fifo #(
        .WIDTH ($bits(res_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_item),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire
